// ----- hdl/code39_barcode_element_encoder_macros.svh -----
// Assertion macros for the Code 39 element encoder.
// Used by the top level; needs clk and rst_n in scope.
`ifndef CODE39_BARCODE_ELEMENT_ENCODER_MACROS_SVH
`define CODE39_BARCODE_ELEMENT_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define C39_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c39 check failed");

// Next-cycle implication, disabled during reset.
`define C39_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c39 check failed");

`endif

// ----- hdl/c39_pkg.sv -----
// Shared types, microcode table and symbol table for the Code 39 encoder.
// No dependencies.
package c39_pkg;

    localparam logic [8:0] STAR_PAT      = 9'h094;
    localparam logic [4:0] QUIET_SPLIT_MAX = 5'd17;
    localparam logic [4:0] PAT_LEN       = 5'd9;

    // register indexes on the APB port (paddr[2])
    localparam logic REG_MODULE_PX = 1'b0;
    localparam logic REG_QUIET_LEN = 1'b1;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_message;
    } sym_word_t;

    typedef struct packed {
        logic       is_bar;
        logic       is_wide;
        logic [9:0] width_px;
        logic       bad_symbol;
        logic       barcode_done;
        logic       last;
    } elem_word_t;

    // one element handed from sequencer to datapath
    typedef struct packed {
        logic valid;
        logic is_bar;
        logic is_wide;
        logic err;
        logic last;
        logic done;
    } emit_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_QUIET,
        K_STAR,
        K_SYM,
        K_GAP,
        K_ERR,
        K_HALT
    } kind_t;

    typedef enum logic [2:0] {
        BR_NONE,
        BR_BAD,
        BR_OPEN,
        BR_NEOM,
        BR_ALWAYS
    } br_t;

    typedef enum logic [1:0] {
        L_NEVER,
        L_NEOM,
        L_QZERO,
        L_FINAL
    } last_sel_t;

    typedef struct packed {
        kind_t      kind;
        br_t        br_cond;
        logic [3:0] br_tgt;
        last_sel_t  last_sel;
    } ctrl_t;

    localparam logic [3:0] PC_ENTRY = 4'd0;
    localparam logic [3:0] PC_SYM   = 4'd5;
    localparam logic [3:0] PC_ERR   = 4'd9;
    localparam logic [3:0] PC_HALT  = 4'd10;

    // control store; PC_HALT doubles as the idle point
    function automatic ctrl_t c39_ucode(input logic [3:0] pc);
        ctrl_t c;
        c = '{kind: K_HALT, br_cond: BR_NONE, br_tgt: PC_HALT, last_sel: L_NEVER};
        case (pc)
            4'd0:    c = '{K_NOP,   BR_BAD,    PC_ERR,  L_NEVER};
            4'd1:    c = '{K_NOP,   BR_OPEN,   PC_SYM,  L_NEVER};
            4'd2:    c = '{K_QUIET, BR_NONE,   PC_HALT, L_NEVER};
            4'd3:    c = '{K_STAR,  BR_NONE,   PC_HALT, L_NEVER};
            4'd4:    c = '{K_GAP,   BR_NONE,   PC_HALT, L_NEVER};
            4'd5:    c = '{K_SYM,   BR_NONE,   PC_HALT, L_NEVER};
            4'd6:    c = '{K_GAP,   BR_NEOM,   PC_HALT, L_NEOM};
            4'd7:    c = '{K_STAR,  BR_NONE,   PC_HALT, L_QZERO};
            4'd8:    c = '{K_QUIET, BR_ALWAYS, PC_HALT, L_FINAL};
            4'd9:    c = '{K_ERR,   BR_ALWAYS, PC_HALT, L_FINAL};
            default: c = '{K_HALT,  BR_NONE,   PC_HALT, L_NEVER};
        endcase
        return c;
    endfunction

    // {known, wide mask}; first element in bit 8
    function automatic logic [9:0] c39_lookup(input logic [7:0] ch);
        logic [9:0] r;
        r = 10'h000;
        case (ch)
            8'h30:   r = {1'b1, 9'h034};
            8'h31:   r = {1'b1, 9'h121};
            8'h32:   r = {1'b1, 9'h061};
            8'h33:   r = {1'b1, 9'h160};
            8'h34:   r = {1'b1, 9'h031};
            8'h35:   r = {1'b1, 9'h130};
            8'h36:   r = {1'b1, 9'h070};
            8'h37:   r = {1'b1, 9'h025};
            8'h38:   r = {1'b1, 9'h124};
            8'h39:   r = {1'b1, 9'h064};
            8'h41:   r = {1'b1, 9'h109};
            8'h42:   r = {1'b1, 9'h049};
            8'h43:   r = {1'b1, 9'h148};
            8'h44:   r = {1'b1, 9'h019};
            8'h45:   r = {1'b1, 9'h118};
            8'h46:   r = {1'b1, 9'h058};
            8'h47:   r = {1'b1, 9'h00D};
            8'h48:   r = {1'b1, 9'h10C};
            8'h49:   r = {1'b1, 9'h04C};
            8'h4A:   r = {1'b1, 9'h01C};
            8'h4B:   r = {1'b1, 9'h103};
            8'h4C:   r = {1'b1, 9'h043};
            8'h4D:   r = {1'b1, 9'h142};
            8'h4E:   r = {1'b1, 9'h013};
            8'h4F:   r = {1'b1, 9'h112};
            8'h50:   r = {1'b1, 9'h052};
            8'h51:   r = {1'b1, 9'h007};
            8'h52:   r = {1'b1, 9'h106};
            8'h53:   r = {1'b1, 9'h046};
            8'h54:   r = {1'b1, 9'h016};
            8'h55:   r = {1'b1, 9'h181};
            8'h56:   r = {1'b1, 9'h0C1};
            8'h57:   r = {1'b1, 9'h1C0};
            8'h58:   r = {1'b1, 9'h091};
            8'h59:   r = {1'b1, 9'h190};
            8'h5A:   r = {1'b1, 9'h0D0};
            8'h2D:   r = {1'b1, 9'h085};
            8'h2E:   r = {1'b1, 9'h184};
            8'h20:   r = {1'b1, 9'h0C4};
            8'h24:   r = {1'b1, 9'h0A8};
            8'h2F:   r = {1'b1, 9'h0A2};
            8'h2B:   r = {1'b1, 9'h08A};
            8'h25:   r = {1'b1, 9'h02A};
            8'h2A:   r = {1'b1, STAR_PAT};
            default: r = 10'h000;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/c39_seq.sv -----
// Microcoded sequencer: step counter, element counter, input latch, message state.
// Depends on c39_pkg (control store, symbol table, emit_t).
module c39_seq import c39_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sym_valid,
    output logic       sym_ready,
    input  sym_word_t  sym_word,
    input  logic [4:0] quiet_len,
    input  logic       slot_free,
    output emit_t      emit
);

    logic [3:0] pc_reg, pc_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       open_reg, open_next;
    logic       open_prev_reg;
    logic       bad_reg;
    logic       eom_reg;
    logic [8:0] pat_reg;
    logic [4:0] q_reg;

    ctrl_t      ctrl;
    logic [4:0] len;
    logic       idle;
    logic       final_elem;
    logic       step_done;
    logic       taken;
    logic       last_raw;
    logic [8:0] pat_sel;
    logic [8:0] pat_shift;
    logic [9:0] lk;
    logic       accept;

    assign ctrl   = c39_ucode(pc_reg);
    assign idle   = (pc_reg == PC_HALT);
    assign accept = sym_valid && sym_ready;
    assign sym_ready = idle;
    assign lk     = c39_lookup(sym_word.symbol);

    always_comb
    begin
        case (ctrl.kind)
            K_QUIET:       len = q_reg;
            K_STAR, K_SYM: len = PAT_LEN;
            K_GAP, K_ERR:  len = 5'd1;
            default:       len = 5'd0;
        endcase
    end

    always_comb
    begin
        case (ctrl.br_cond)
            BR_BAD:    taken = bad_reg;
            BR_OPEN:   taken = open_prev_reg;
            BR_NEOM:   taken = !eom_reg;
            BR_ALWAYS: taken = 1'b1;
            default:   taken = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.last_sel)
            L_NEOM:  last_raw = !eom_reg;
            L_QZERO: last_raw = (q_reg == 5'd0);
            L_FINAL: last_raw = 1'b1;
            default: last_raw = 1'b0;
        endcase
    end

    assign final_elem = (cnt_reg == (len - 5'd1));
    assign step_done  = (len == 5'd0) || (slot_free && final_elem);
    assign pat_sel    = (ctrl.kind == K_STAR) ? STAR_PAT : pat_reg;
    assign pat_shift  = pat_sel << cnt_reg[3:0];

    always_comb
    begin
        emit.valid   = !idle && (len != 5'd0) && slot_free;
        emit.err     = (ctrl.kind == K_ERR);
        emit.is_bar  = ((ctrl.kind == K_STAR) || (ctrl.kind == K_SYM)) && !cnt_reg[0];
        emit.is_wide = ((ctrl.kind == K_STAR) || (ctrl.kind == K_SYM)) && pat_shift[8];
        emit.last    = last_raw && final_elem;
        emit.done    = last_raw && final_elem && eom_reg && (ctrl.kind != K_ERR);
    end

    always_comb
    begin
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        open_next = open_reg;
        if (idle)
        begin
            if (accept)
            begin
                pc_next   = PC_ENTRY;
                cnt_next  = 5'd0;
                open_next = lk[9] && !sym_word.end_of_message;
            end
        end
        else if (step_done)
        begin
            cnt_next = 5'd0;
            pc_next  = taken ? ctrl.br_tgt : (pc_reg + 4'd1);
        end
        else if (emit.valid)
        begin
            cnt_next = cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_HALT;
            cnt_reg  <= 5'd0;
            open_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
            open_reg <= open_next;
        end
    end

    // item latch, payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            open_prev_reg <= open_reg;
            bad_reg       <= !lk[9];
            eom_reg       <= sym_word.end_of_message;
            pat_reg       <= lk[8:0];
            if (!open_reg && sym_word.end_of_message && (quiet_len > QUIET_SPLIT_MAX))
                q_reg <= QUIET_SPLIT_MAX;
            else
                q_reg <= quiet_len;
        end
    end

endmodule

// ----- hdl/c39_dp.sv -----
// Element datapath: pixel width and the output word register.
// Depends on c39_pkg (emit_t, elem_word_t).
module c39_dp import c39_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] module_px,
    input  emit_t      emit,
    output logic       slot_free,
    output logic       elem_valid,
    input  logic       elem_ready,
    output elem_word_t elem_word
);

    logic       valid_reg;
    elem_word_t word_reg;
    logic [9:0] wide_px;

    // 2m + m/2
    assign wide_px   = {1'b0, module_px, 1'b0} + {3'b000, module_px[7:1]};
    assign slot_free = !valid_reg || elem_ready;
    assign elem_valid = valid_reg;
    assign elem_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (emit.valid)
            valid_reg <= 1'b1;
        else if (elem_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            word_reg.is_bar       <= emit.is_bar;
            word_reg.is_wide      <= emit.is_wide;
            word_reg.bad_symbol   <= emit.err;
            word_reg.barcode_done <= emit.done;
            word_reg.last         <= emit.last;
            if (emit.err)
                word_reg.width_px <= 10'd0;
            else if (emit.is_wide)
                word_reg.width_px <= wide_px;
            else
                word_reg.width_px <= {2'b00, module_px};
        end
    end

endmodule

// ----- hdl/code39_barcode_element_encoder.sv -----
// Top level of the Code 39 element encoder: APB registers, sequencer, datapath.
// Depends on c39_pkg, c39_seq, c39_dp and the assertion macro header.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------------
//  sym     | in        | sym_valid / sym_ready  | sym_word_t: symbol, end_of_message
//  elem    | out       | elem_valid / elem_ready| elem_word_t: one bar or space
//  apb     | in        | psel/penable, pready=1 | module_px @0x0, quiet_len @0x4
//
// Sequencing: a known character runs two dispatch steps and then its element
// steps, empty quiet zone steps included; the next item is accepted once idle.
// The sequencer issues one element per cycle from its control store while the
// elem output is not stalled. An unknown character issues one error element.
// Reset clears the step counter (to idle), message state and output valid;
// registers return to module_px=2, quiet_len=10. No clearing pass.
// A stall on elem holds the sequencer in place; sym_ready is high while idle.
`include "code39_barcode_element_encoder_macros.svh"

module code39_barcode_element_encoder import c39_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // character input
    input  logic        sym_valid,
    output logic        sym_ready,
    input  sym_word_t   sym_word,
    // element output
    output logic        elem_valid,
    input  logic        elem_ready,
    output elem_word_t  elem_word
);

    logic [7:0] module_px_reg;
    logic [4:0] quiet_len_reg;
    logic       cfg_wr;
    logic       slot_free;
    emit_t      emit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // registers decode on paddr[2] only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_px_reg <= 8'd2;
            quiet_len_reg <= 5'd10;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MODULE_PX: module_px_reg <= pwdata[7:0];
                REG_QUIET_LEN: quiet_len_reg <= pwdata[4:0];
                default:       module_px_reg <= module_px_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODULE_PX: prdata = {24'd0, module_px_reg};
            REG_QUIET_LEN: prdata = {27'd0, quiet_len_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // step counter and control store walk the element program
    c39_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym_word  (sym_word),
        .quiet_len (quiet_len_reg),
        .slot_free (slot_free),
        .emit      (emit)
    );

    // width computation and the output register
    c39_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .module_px  (module_px_reg),
        .emit       (emit),
        .slot_free  (slot_free),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .elem_word  (elem_word)
    );

    // no element issued while the sequencer sits idle
    `C39_ASSERT_IMPL(a_no_emit_idle, emit.valid, !sym_ready)
    // sequencer only issues into a free output slot
    `C39_ASSERT_IMPL(a_emit_slot, emit.valid, slot_free)
    // an accepted character always starts the program
    `C39_ASSERT_NEXT(a_busy_after_accept, sym_valid && sym_ready, !sym_ready)
    // error words are single, zero width, and never close a barcode
    `C39_ASSERT_IMPL(a_err_word, elem_valid && elem_word.bad_symbol,
        elem_word.last && (elem_word.width_px == 10'd0) && !elem_word.barcode_done)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for code39_barcode_element_encoder.
// Depends on c39_pkg and the encoder RTL; predicts every element word and checks it in order.

module tb_top import c39_pkg::*;;

    // Run length guard: worst case is ~225 words x 64 elements with short stalls.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_WORDS  = 40;
    localparam int ROW_COUNT    = 23;

    // Code 39 character set and the matching wide masks (first element in bit 8).
    localparam int SET_SIZE = 44;
    localparam logic [SET_SIZE*8-1:0] CHARSET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%*";
    localparam logic [SET_SIZE*9-1:0] WIDE_MASKS = {
        9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
        9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
        9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
        9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
        9'h085, 9'h184, 9'h0C4, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A, 9'h094
    };

    // Words whose value can be read straight off the spec.
    localparam elem_word_t BAD_WORD = '{is_bar: 1'b0, is_wide: 1'b0, width_px: 10'd0,
                                        bad_symbol: 1'b1, barcode_done: 1'b0, last: 1'b1};
    // first quiet-zone space after reset: narrow, module_px = 2
    localparam elem_word_t RESET_QUIET = '{is_bar: 1'b0, is_wide: 1'b0, width_px: 10'd2,
                                           bad_symbol: 1'b0, barcode_done: 1'b0, last: 1'b0};
    localparam elem_word_t NO_FIRST = '0;

    typedef struct packed {
        logic [7:0] symbol;
        logic       eom;
        logic       has_first;   // first element word typed in below
        elem_word_t first;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        sym_valid;
    logic        sym_ready;
    sym_word_t   sym_word;
    logic        elem_valid;
    logic        elem_ready;
    elem_word_t  elem_word;

    // Predictor state: its own copy of the registers and the open-message flag.
    logic [7:0]  cfg_module;
    logic [4:0]  cfg_quiet;
    logic        msg_open;

    // Elements of the current character, then the queue of words still owed by the DUT.
    elem_word_t  elem_burst [0:63];
    int          burst_len;
    elem_word_t  pending_elems [$];

    int          fail_count;
    int          cycle_count;
    logic        steady;     // no idling on either side while set

    // Directed words: message framing, every character class, bad characters
    // when closed, in the middle of a message and with the end flag set.
    stim_row_t directed_rows [ROW_COUNT] = '{
        '{"H",   1'b0, 1'b1, RESET_QUIET},   // opens first message after reset
        '{"E",   1'b0, 1'b0, NO_FIRST},
        '{"L",   1'b0, 1'b0, NO_FIRST},
        '{"P",   1'b1, 1'b0, NO_FIRST},      // closes: stop symbol + quiet zone
        '{8'h00, 1'b0, 1'b1, BAD_WORD},      // lowest byte, unknown
        '{"*",   1'b1, 1'b0, NO_FIRST},      // one-word message, star as data
        '{"0",   1'b0, 1'b0, NO_FIRST},
        '{"9",   1'b0, 1'b0, NO_FIRST},
        '{"A",   1'b0, 1'b0, NO_FIRST},
        '{"Z",   1'b0, 1'b0, NO_FIRST},
        '{"-",   1'b0, 1'b0, NO_FIRST},
        '{".",   1'b0, 1'b0, NO_FIRST},
        '{" ",   1'b0, 1'b0, NO_FIRST},
        '{8'hFF, 1'b0, 1'b1, BAD_WORD},      // highest byte aborts open message
        '{"$",   1'b0, 1'b0, NO_FIRST},      // new message after the abort
        '{"/",   1'b0, 1'b0, NO_FIRST},
        '{"+",   1'b0, 1'b0, NO_FIRST},
        '{"%",   1'b1, 1'b0, NO_FIRST},
        '{"a",   1'b1, 1'b1, BAD_WORD},      // lower case is not in the set
        '{8'h80, 1'b0, 1'b1, BAD_WORD},
        '{"Q",   1'b1, 1'b0, NO_FIRST},      // one-word message
        '{"W",   1'b0, 1'b0, NO_FIRST},
        '{8'h7F, 1'b1, 1'b1, BAD_WORD}       // unknown with end flag, mid-message
    };

    code39_barcode_element_encoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sym_valid  (sym_valid),
        .sym_ready  (sym_ready),
        .sym_word   (sym_word),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .elem_word  (elem_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d element words still expected", $time,
                 pending_elems.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] set_char(input int idx);
        return CHARSET[(SET_SIZE-1-idx)*8 +: 8];
    endfunction

    // Position of a character in the set, -1 when unknown.
    function automatic int find_symbol(input logic [7:0] ch);
        int i;
        for (i = 0; i < SET_SIZE; i++)
        begin
            if (set_char(i) == ch)
                return i;
        end
        return -1;
    endfunction

    // Narrow is one module; wide is 2.5 modules rounded down.
    task automatic push_elem(input logic bar, input logic wide);
        elem_word_t e;
        logic [9:0] m;
        m = {2'b00, cfg_module};
        e = '0;
        e.is_bar   = bar;
        e.is_wide  = wide;
        e.width_px = wide ? (m << 1) + (m >> 1) : m;
        elem_burst[burst_len] = e;
        burst_len++;
    endtask

    // Nine elements, bar first, alternating.
    task automatic push_pattern(input logic [8:0] mask);
        int k;
        for (k = 0; k < 9; k++)
            push_elem(~k[0], mask[8-k]);
    endtask

    task automatic push_quiet(input logic [4:0] count);
        int k;
        for (k = 0; k < count; k++)
            push_elem(1'b0, 1'b0);
    endtask

    // Works out the element words one accepted character causes and queues them.
    task automatic predict_words(input sym_word_t w, input logic has_first,
                                 input elem_word_t first);
        int idx;
        int k;
        logic [4:0] q;
        burst_len = 0;
        idx = find_symbol(w.symbol);
        if (idx < 0)
        begin
            // unknown character: one error word, message dropped
            elem_burst[0] = BAD_WORD;
            burst_len = 1;
            msg_open = 1'b0;
        end
        else
        begin
            q = cfg_quiet;
            // a one-word message caps each quiet zone so it fits in 64 words
            if (!msg_open && w.end_of_message && q > QUIET_SPLIT_MAX)
                q = QUIET_SPLIT_MAX;
            if (!msg_open)
            begin
                push_quiet(q);
                push_pattern(STAR_PAT);
                push_elem(1'b0, 1'b0);
                msg_open = 1'b1;
            end
            push_pattern(WIDE_MASKS[(SET_SIZE-1-idx)*9 +: 9]);
            push_elem(1'b0, 1'b0);
            if (w.end_of_message)
            begin
                push_pattern(STAR_PAT);
                push_quiet(q);
                // with an empty quiet zone this lands on the stop symbol's last bar
                elem_burst[burst_len-1].barcode_done = 1'b1;
                msg_open = 1'b0;
            end
            elem_burst[burst_len-1].last = 1'b1;
        end
        if (has_first)
            elem_burst[0] = first;
        for (k = 0; k < burst_len; k++)
            pending_elems.push_back(elem_burst[k]);
    endtask

    // ------------------------------------------------------------------
    // Drivers (inputs change on the falling edge)
    // ------------------------------------------------------------------

    // APB write with a setup and an access phase; register lands when psel/penable/pwrite/pready are high.
    task automatic reg_write(input logic reg_idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_idx == REG_MODULE_PX)
            cfg_module = value[7:0];
        else
            cfg_quiet = value[4:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offers one character word; returns at the falling edge after acceptance
    // with valid still high, so back-to-back words drop valid only for random idles outside the steady stretch.
    task automatic send_word(input sym_word_t w, input logic has_first,
                             input elem_word_t first);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 7)
            begin
                sym_valid = 1'b0;
                @(negedge clk);
            end
        end
        sym_word  = w;
        sym_valid = 1'b1;
        do @(posedge clk); while (!sym_ready);
        predict_words(w, has_first, first);
        @(negedge clk);
    endtask

    // Mostly well-formed messages with random content; the rest is noise
    // bytes, messages left open and messages cut short by a bad byte.
    task automatic run_random(input int word_count);
        int sent;
        int kind;
        int len;
        int k;
        sym_word_t w;
        sent = 0;
        while (sent < word_count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                w.symbol         = 8'($urandom_range(0, 255));
                w.end_of_message = 1'($urandom_range(0, 1));
                send_word(w, 1'b0, NO_FIRST);
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                begin
                    w.symbol         = set_char($urandom_range(0, SET_SIZE-1));
                    w.end_of_message = (k == len - 1);
                    if (k == len - 1 && kind >= 95)
                        w.symbol = 8'h80 | 8'($urandom_range(0, 127));  // never valid
                    else if (k == len - 1 && kind >= 90)
                        w.end_of_message = 1'b0;                        // left open
                    send_word(w, 1'b0, NO_FIRST);
                    sent++;
                end
            end
        end
    endtask

    // Drops valid and waits for every owed element word.
    task automatic drain;
        sym_valid = 1'b0;
        while (pending_elems.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Element sink: held off in reset, random back-pressure, none during the steady stretch.
    always @(negedge clk)
    begin
        elem_ready = rst_n && (steady || ($urandom_range(0, 99) >= 7));
    end

    // ------------------------------------------------------------------
    // Checker (outputs sampled on the rising edge)
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_elements
        elem_word_t want;
        if (rst_n && elem_valid && elem_ready)
        begin
            if (pending_elems.size() == 0)
            begin
                $display("%0t: unexpected element word: expected none, got %p",
                         $time, elem_word);
                fail_count++;
            end
            else
            begin
                want = pending_elems.pop_front();
                if (elem_word !== want)
                begin
                    $display("%0t: element mismatch:", $time,
                             " expected bar=%b wide=%b px=%0d bad=%b done=%b last=%b,",
                             want.is_bar, want.is_wide, want.width_px,
                             want.bad_symbol, want.barcode_done, want.last,
                             " got bar=%b wide=%b px=%0d bad=%b done=%b last=%b",
                             elem_word.is_bar, elem_word.is_wide, elem_word.width_px,
                             elem_word.bad_symbol, elem_word.barcode_done, elem_word.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        int r;
        int p;
        sym_word_t w;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        sym_valid   = 1'b0;
        sym_word    = '0;
        steady      = 1'b0;
        cfg_module  = 8'd2;
        cfg_quiet   = 5'd10;
        msg_open    = 1'b0;
        burst_len   = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at reset register values
        for (r = 0; r < ROW_COUNT; r++)
        begin
            w.symbol         = directed_rows[r].symbol;
            w.end_of_message = directed_rows[r].eom;
            send_word(w, directed_rows[r].has_first, directed_rows[r].first);
        end
        drain();

        // random phases: narrowest module with no quiet zone, widest module with
        // the longest quiet zone, zero module width (run without idling), then random
        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    reg_write(REG_MODULE_PX, 32'd1);
                    reg_write(REG_QUIET_LEN, 32'd0);
                end
                1:
                begin
                    reg_write(REG_MODULE_PX, 32'd255);
                    reg_write(REG_QUIET_LEN, 32'd31);
                end
                2:
                begin
                    reg_write(REG_MODULE_PX, 32'd0);
                    reg_write(REG_QUIET_LEN, 32'd17);
                end
                default:
                begin
                    reg_write(REG_MODULE_PX, $urandom_range(1, 255));
                    reg_write(REG_QUIET_LEN, $urandom_range(0, 31));
                end
            endcase
            steady = (p == 2);
            run_random(PHASE_WORDS);
            drain();
            steady = 1'b0;
        end

        // catch stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
